// ===== design/prs_pkg.sv =====
// prs_pkg: shared widths, register indexes, lane result and merge control types
// for the packed range scan block; depends on nothing
package prs_pkg;

  // word and accumulator geometry
  localparam int WORD_BITS_DEFAULT = 64;
  localparam int ACC_W             = 64;
  localparam int POS_W             = 6;

  // configuration register geometry
  localparam int CODE_W     = 5;
  localparam int CODE_MAX   = 31;
  localparam int CFG_DATA_W = 31;
  localparam int INDEX_W    = 2;

  localparam logic [CODE_W-1:0] CODE_BITS_RESET = 5'd7;

  // register indexes of the configuration port
  localparam logic [INDEX_W-1:0] REG_CODE_BITS   = 2'd0;
  localparam logic [INDEX_W-1:0] REG_LOWER_LIMIT = 2'd1;
  localparam logic [INDEX_W-1:0] REG_UPPER_LIMIT = 2'd2;

  // what one lane found for its slot
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] place;
  } lane_result_t;

  // control from the pipeline to the merging stage
  typedef struct packed {
    logic drain;
    logic last;
  } merge_ctrl_t;

endpackage

// ===== design/prs_word_if.sv =====
// prs_word_if: input channel carrying one packed word per transfer
// depends on prs_pkg for the accumulator width
interface prs_word_if;
  logic                      valid;
  logic                      ready;
  logic [prs_pkg::ACC_W-1:0] packed_word;

  modport source (output valid, output packed_word, input ready);
  modport sink (input valid, input packed_word, output ready);
endinterface

// ===== design/prs_match_if.sv =====
// prs_match_if: output channel carrying one match vector per transfer
// depends on prs_pkg for the accumulator width
interface prs_match_if;
  logic                      valid;
  logic                      ready;
  logic [prs_pkg::ACC_W-1:0] match_vector;

  modport source (output valid, output match_vector, input ready);
  modport sink (input valid, input match_vector, output ready);
endinterface

// ===== design/prs_lane.sv =====
// prs_lane: range test of one code slot of a word, placing its
// delimiter bit after the segment shift; depends on prs_pkg
module prs_lane #(
  parameter int WORD_BITS  = prs_pkg::WORD_BITS_DEFAULT,
  parameter int LANE_INDEX = 0
) (
  input  logic [WORD_BITS-1:0]         word,
  input  logic [prs_pkg::CODE_W-1:0]   code_bits,
  input  logic [prs_pkg::CODE_MAX-1:0] lower_limit,
  input  logic [prs_pkg::CODE_MAX-1:0] upper_limit,
  input  logic [prs_pkg::POS_W-1:0]    word_position,
  output prs_pkg::lane_result_t        result
);

  localparam int EXT_W = WORD_BITS + prs_pkg::CODE_MAX;
  localparam int IDX_W = $clog2(WORD_BITS);
  localparam int OFF_W = $clog2(WORD_BITS * (prs_pkg::CODE_MAX + 1)) + 1;

  logic [OFF_W-1:0]             slot;
  logic [OFF_W-1:0]             offset;
  logic [OFF_W-1:0]             delim;
  logic                         fits;
  logic                         reaches;
  logic [EXT_W-1:0]             shifted;
  logic [prs_pkg::CODE_MAX-1:0] cmask;
  logic [prs_pkg::CODE_MAX-1:0] code;
  logic [prs_pkg::CODE_MAX-1:0] lo;
  logic [prs_pkg::CODE_MAX-1:0] hi;
  logic                         in_range;

  // slot placement for this lane
  assign slot   = OFF_W'(code_bits) + OFF_W'(1);
  assign offset = OFF_W'(LANE_INDEX) * slot;
  assign fits   = (offset + slot) <= OFF_W'(WORD_BITS);
  assign delim  = offset + OFF_W'(code_bits);

  // code extraction and bound masking
  assign shifted = EXT_W'(word) >> offset[IDX_W-1:0];
  assign cmask   = prs_pkg::CODE_MAX'((32'd1 << code_bits) - 32'd1);
  assign code    = shifted[prs_pkg::CODE_MAX-1:0] & cmask;
  assign lo      = lower_limit & cmask;
  assign hi      = upper_limit & cmask;

  // strict range test
  assign in_range = (code > lo) && (code < hi);

  // delimiter bit survives the segment shift only if at or above it
  assign reaches      = delim >= OFF_W'(word_position);
  assign result.hit   = fits && in_range && reaches;
  assign result.place = prs_pkg::POS_W'(delim - OFF_W'(word_position));

endmodule

// ===== design/prs_merge.sv =====
// prs_merge: combines lane results into the segment accumulator
// depends on prs_pkg for lane result and control types
module prs_merge #(
  parameter int NUM_LANES = prs_pkg::WORD_BITS_DEFAULT / 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  prs_pkg::merge_ctrl_t                  ctrl,
  input  prs_pkg::lane_result_t [NUM_LANES-1:0] lanes,
  output logic [prs_pkg::ACC_W-1:0]             merged
);

  logic [prs_pkg::ACC_W-1:0] match_accumulator;
  logic [prs_pkg::ACC_W-1:0] contrib;

  // decode each lane's bit place and or them together
  always_comb begin
    contrib = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      if (lanes[k].hit) begin
        contrib = contrib | (prs_pkg::ACC_W'(1) << lanes[k].place);
      end
    end
  end

  assign merged = match_accumulator | contrib;

  // accumulate, clear after the segment's last word
  always_ff @(posedge clk) begin
    if (rst) begin
      match_accumulator <= '0;
    end else if (ctrl.drain) begin
      match_accumulator <= ctrl.last ? '0 : merged;
    end
  end

endmodule

// ===== design/packed_range_scan.sv =====
// packed_range_scan: top level of the packed-code range scan
// depends on prs_pkg, prs_word_if, prs_match_if, prs_lane and prs_merge
//
// Usage: packed words arrive on the words channel, one per transfer.
// Each word holds codes of code_bits bits in slots of code_bits+1 bits;
// a segment is code_bits+1 words. After the last word of a segment one
// match vector leaves on the vectors channel, with the delimiter bit of
// each code strictly between lower_limit and upper_limit set, word j's
// bits shifted right by j. Registers are written through the plain
// cfg_write_enable / cfg_index / cfg_data port; the user must write them
// only while no word is in flight; the block does not enforce it.
// Throughput: one word per cycle unless a finished segment is stalled;
// pipeline: input register, one lane per possible slot, accumulator merge.
// Output: the vector is registered after merging the segment's last word.
// Stall: a stalled receiver holds only the segment that has finished;
// words keep flowing until a second finished segment reaches the merge.
// Reset: synchronous, clears the pipeline, word position and
// accumulator, and sets code_bits to 7 and both limits to 0.
module packed_range_scan #(
  parameter int WORD_BITS = prs_pkg::WORD_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  prs_word_if.sink                       words,
  prs_match_if.source                    vectors,
  input  logic                           cfg_write_enable,
  input  logic [prs_pkg::INDEX_W-1:0]    cfg_index,
  input  logic [prs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NUM_LANES = WORD_BITS / 2;

  // configuration registers
  logic [prs_pkg::CODE_W-1:0]   code_bits;
  logic [prs_pkg::CODE_MAX-1:0] lower_limit;
  logic [prs_pkg::CODE_MAX-1:0] upper_limit;
  logic [prs_pkg::CODE_W-1:0]   eff_code_bits;

  // segment tracking
  logic [prs_pkg::POS_W-1:0] word_position;
  logic                      is_last;
  logic                      accept;

  // stage 1: registered word
  logic                      v1;
  logic                      last1;
  logic [prs_pkg::POS_W-1:0] pos1;
  logic [WORD_BITS-1:0]      word1;

  // stage 2: registered lane results
  logic                                  v2;
  logic                                  last2;
  prs_pkg::lane_result_t [NUM_LANES-1:0] lane_out;
  prs_pkg::lane_result_t [NUM_LANES-1:0] lane_q;

  // output register
  logic                      out_valid;
  logic [prs_pkg::ACC_W-1:0] out_vector;
  logic [prs_pkg::ACC_W-1:0] merged;

  // flow control
  logic                 drain2;
  logic                 s2_free;
  logic                 stall2;
  prs_pkg::merge_ctrl_t merge_ctrl;

  // configuration writes, out of range index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits   <= prs_pkg::CODE_BITS_RESET;
      lower_limit <= '0;
      upper_limit <= '0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        prs_pkg::REG_CODE_BITS:   code_bits   <= cfg_data[prs_pkg::CODE_W-1:0];
        prs_pkg::REG_LOWER_LIMIT: lower_limit <= cfg_data[prs_pkg::CODE_MAX-1:0];
        prs_pkg::REG_UPPER_LIMIT: upper_limit <= cfg_data[prs_pkg::CODE_MAX-1:0];
        default: ;
      endcase
    end
  end

  // a code width of zero acts as one
  assign eff_code_bits = (code_bits == '0) ? prs_pkg::CODE_W'(1) : code_bits;

  // handshake and stall chain
  assign stall2        = v2 && last2 && out_valid && !vectors.ready;
  assign drain2        = v2 && !stall2;
  assign s2_free       = !v2 || drain2;
  assign words.ready   = !v1 || s2_free;
  assign accept        = words.valid && words.ready;
  assign is_last       = word_position >= prs_pkg::POS_W'(eff_code_bits);

  // word position within the segment
  always_ff @(posedge clk) begin
    if (rst) begin
      word_position <= '0;
    end else if (accept) begin
      word_position <= is_last ? '0 : word_position + prs_pkg::POS_W'(1);
    end
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (words.ready) begin
      v1 <= words.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word1 <= words.packed_word[WORD_BITS-1:0];
      last1 <= is_last;
      pos1  <= word_position;
    end
  end

  // one lane per possible slot of the word
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    prs_lane #(
      .WORD_BITS  (WORD_BITS),
      .LANE_INDEX (k)
    ) u_lane (
      .word          (word1),
      .code_bits     (eff_code_bits),
      .lower_limit   (lower_limit),
      .upper_limit   (upper_limit),
      .word_position (pos1),
      .result        (lane_out[k])
    );
  end

  // stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_free) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && s2_free) begin
      lane_q <= lane_out;
      last2  <= last1;
    end
  end

  // merge into the accumulator
  assign merge_ctrl.drain = drain2;
  assign merge_ctrl.last  = last2;

  prs_merge #(
    .NUM_LANES (NUM_LANES)
  ) u_merge (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (merge_ctrl),
    .lanes  (lane_q),
    .merged (merged)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain2 && last2) begin
      out_valid <= 1'b1;
    end else if (vectors.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain2 && last2) begin
      out_vector <= merged;
    end
  end

  assign vectors.valid        = out_valid;
  assign vectors.match_vector = out_vector;

`ifndef SYNTHESIS
  // input only backs up behind a finished segment and a full output
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !words.ready |-> (v1 && v2 && last2 && out_valid))
    else $error("input stalled without a blocked segment end");

  // a stalled segment end stays in stage 2
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    stall2 |=> (v2 && last2))
    else $error("stalled segment end lost from stage 2");

  // a new result comes only from a drained segment end
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(drain2 && last2))
    else $error("match vector without a segment end");
`endif

endmodule
